// ===== design/utf8d_pkg.sv =====
// shared types, widths and codes for the utf-8 stream decoder
package utf8d_pkg;

  localparam int unsigned CP_W      = 26;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned PTR_W     = $clog2(CMD_DEPTH);
  localparam int unsigned FILL_W    = $clog2(CMD_DEPTH + 1);

  // class of a byte seen as the start of a sequence
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_FIVE,
    LEAD_BAD
  } lead_e;

  // work handed from front to back: a run of error results, then an optional character
  typedef struct packed {
    logic [CNT_W-1:0] err_cnt;
    logic             has_char;
    logic [CP_W-1:0]  cp;
    logic [CNT_W-1:0] used;
  } cmd_t;

  function automatic lead_e classify(input logic [BYTE_W-1:0] b);
    lead_e res;
    if (b[7] == 1'b0) begin
      res = LEAD_ASCII;
    end else if (b[7:5] == 3'b110) begin
      res = LEAD_TWO;
    end else if (b[7:4] == 4'b1110) begin
      res = LEAD_THREE;
    end else if (b[7:3] == 5'b11110) begin
      res = LEAD_FOUR;
    end else if (b[7:2] == 6'b111110) begin
      res = LEAD_FIVE;
    end else begin
      res = LEAD_BAD;
    end
    return res;
  endfunction

endpackage

// ===== design/utf8d_front.sv =====
// front end: sequence state and classification of each input byte into a command
module utf8d_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [utf8d_pkg::BYTE_W-1:0]   byte_value_i,
  input  logic                           end_of_data_i,
  input  logic                           full_i,
  output logic                           push_o,
  output utf8d_pkg::cmd_t                cmd_o
);

  logic [utf8d_pkg::CP_W-1:0]  pv_q, pv_d;
  logic [utf8d_pkg::CNT_W-1:0] need_q, need_d;
  logic [utf8d_pkg::CNT_W-1:0] seen_q, seen_d;
  logic [utf8d_pkg::CNT_W-1:0] seen_inc;
  logic                        is_cont;
  logic                        accept;
  utf8d_pkg::lead_e            lead;
  utf8d_pkg::cmd_t             cmd;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign is_cont    = (byte_value_i[7:6] == 2'b10);
  assign seen_inc   = seen_q + 3'd1;
  assign lead       = utf8d_pkg::classify(byte_value_i);

  always_comb begin
    pv_d         = pv_q;
    need_d       = need_q;
    seen_d       = seen_q;
    cmd.err_cnt  = '0;
    cmd.has_char = 1'b0;
    cmd.cp       = '0;
    cmd.used     = 3'd1;
    if (need_q != '0 && is_cont) begin
      pv_d   = {pv_q[utf8d_pkg::CP_W-7:0], byte_value_i[5:0]};
      seen_d = seen_inc;
      if (seen_inc >= need_q) begin
        cmd.has_char = 1'b1;
        cmd.cp       = {pv_q[utf8d_pkg::CP_W-7:0], byte_value_i[5:0]};
        cmd.used     = need_q;
        pv_d         = '0;
        need_d       = '0;
        seen_d       = '0;
      end else if (end_of_data_i) begin
        cmd.err_cnt = seen_inc;
        pv_d        = '0;
        need_d      = '0;
        seen_d      = '0;
      end
    end else begin
      // an open sequence broken by a non-continuation byte: one error per byte taken
      cmd.err_cnt = (need_q != '0) ? seen_q : '0;
      pv_d        = '0;
      need_d      = '0;
      seen_d      = '0;
      case (lead)
        utf8d_pkg::LEAD_ASCII: begin
          cmd.has_char = 1'b1;
          cmd.cp       = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, byte_value_i};
        end
        utf8d_pkg::LEAD_TWO: begin
          need_d = 3'd2;
          seen_d = 3'd1;
          pv_d   = {{(utf8d_pkg::CP_W-5){1'b0}}, byte_value_i[4:0]};
        end
        utf8d_pkg::LEAD_THREE: begin
          need_d = 3'd3;
          seen_d = 3'd1;
          pv_d   = {{(utf8d_pkg::CP_W-4){1'b0}}, byte_value_i[3:0]};
        end
        utf8d_pkg::LEAD_FOUR: begin
          need_d = 3'd4;
          seen_d = 3'd1;
          pv_d   = {{(utf8d_pkg::CP_W-3){1'b0}}, byte_value_i[2:0]};
        end
        utf8d_pkg::LEAD_FIVE: begin
          need_d = 3'd5;
          seen_d = 3'd1;
          pv_d   = {{(utf8d_pkg::CP_W-2){1'b0}}, byte_value_i[1:0]};
        end
        default: begin
          cmd.err_cnt = cmd.err_cnt + 3'd1;
        end
      endcase
      // lead opened on the final byte: truncated at once
      if (end_of_data_i && need_d != '0) begin
        cmd.err_cnt = cmd.err_cnt + 3'd1;
        pv_d        = '0;
        need_d      = '0;
        seen_d      = '0;
      end
    end
  end

  assign push_o = accept && (cmd.err_cnt != '0 || cmd.has_char);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= '0;
      need_q <= '0;
      seen_q <= '0;
    end else if (accept) begin
      pv_q   <= pv_d;
      need_q <= need_d;
      seen_q <= seen_d;
    end
  end

endmodule

// ===== design/utf8d_cmd_fifo.sv =====
// short command queue between front and back
module utf8d_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  utf8d_pkg::cmd_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            not_empty_o,
  output utf8d_pkg::cmd_t head_o
);

  utf8d_pkg::cmd_t               mem_q [utf8d_pkg::CMD_DEPTH];
  logic [utf8d_pkg::PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [utf8d_pkg::FILL_W-1:0]  fill_q;
  logic                          do_push, do_pop;

  assign full_o      = (fill_q == utf8d_pkg::FILL_W'(utf8d_pkg::CMD_DEPTH));
  assign not_empty_o = (fill_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// ===== design/utf8d_back.sv =====
// back end: expands each command into result beats through an output register
module utf8d_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  utf8d_pkg::cmd_t              cmd_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [utf8d_pkg::CP_W-1:0]   code_point_o,
  output logic                         is_valid_o,
  output logic [utf8d_pkg::CNT_W-1:0]  bytes_used_o,
  output logic                         last_of_run_o
);

  logic [utf8d_pkg::CNT_W-1:0] idx_q;
  logic [utf8d_pkg::CNT_W-1:0] total;
  logic                        err_slot;
  logic                        last;
  logic                        load;
  logic                        out_valid_q;
  logic [utf8d_pkg::CP_W-1:0]  cp_q;
  logic                        ok_q;
  logic [utf8d_pkg::CNT_W-1:0] used_q;
  logic                        last_q;

  assign total    = cmd_i.err_cnt + {2'b00, cmd_i.has_char};
  assign err_slot = (idx_q < cmd_i.err_cnt);
  assign last     = ((idx_q + 3'd1) == total);
  assign load     = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o    = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= last ? '0 : idx_q + 3'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= err_slot ? '0 : cmd_i.cp;
      ok_q   <= !err_slot;
      used_q <= err_slot ? 3'd1 : cmd_i.used;
      last_q <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = cp_q;
  assign is_valid_o    = ok_q;
  assign bytes_used_o  = used_q;
  assign last_of_run_o = last_q;

endmodule

// ===== design/utf8_stream_decoder.sv =====
// top level of the byte-serial utf-8 decoder (1 to 5 byte sequences)
// path: a byte's first result beat passes through the command queue, then the output register
// throughput: one byte per cycle while each byte gives at most one result and the receiver
//   does not stall; a byte that gives k results holds the back end until its expander has sent all k beats
// the 4-entry command queue lets the front keep taking bytes during error runs
// reset: rst_ni low clears sequence state, queue and output valid asynchronously
module utf8_stream_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // byte input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [utf8d_pkg::BYTE_W-1:0] byte_value_i,
  input  logic                         end_of_data_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [utf8d_pkg::CP_W-1:0]   code_point_o,
  output logic                         is_valid_o,
  output logic [utf8d_pkg::CNT_W-1:0]  bytes_used_o,
  output logic                         last_of_run_o
);

  // front to queue
  logic            push;
  utf8d_pkg::cmd_t push_cmd;
  logic            full;
  // queue to back
  logic            pop;
  logic            head_valid;
  utf8d_pkg::cmd_t head_cmd;

  // front: holds the open sequence and turns each byte into at most one command
  utf8d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_value_i  (byte_value_i),
    .end_of_data_i (end_of_data_i),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  // commands wait here so front and back stall independently
  utf8d_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .not_empty_o (head_valid),
    .head_o      (head_cmd)
  );

  // back: error beats first, then the decoded character, last beat flagged
  utf8d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (head_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_point_o  (code_point_o),
    .is_valid_o    (is_valid_o),
    .bytes_used_o  (bytes_used_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== design/utf8d_checker.sv =====
// port-level checker for the utf-8 stream decoder, bound to the top level
module utf8d_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [utf8d_pkg::BYTE_W-1:0] byte_value_i,
  input logic                         end_of_data_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [utf8d_pkg::CP_W-1:0]   code_point_o,
  input logic                         is_valid_o,
  input logic [utf8d_pkg::CNT_W-1:0]  bytes_used_o,
  input logic                         last_of_run_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_point_o) &&
      $stable(is_valid_o) && $stable(bytes_used_o) && $stable(last_of_run_o))
    else $error("result beat changed while stalled");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_valid_o |-> code_point_o == '0 && bytes_used_o == 3'd1)
    else $error("error beat with nonzero code point or length");

  // a decoded character always closes the run of its byte
  a_char_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_valid_o |-> last_of_run_o)
    else $error("decoded character not last of run");

  a_char_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_valid_o |-> bytes_used_o >= 3'd1 && bytes_used_o <= 3'd5 &&
      (bytes_used_o != 3'd1 || code_point_o < 26'd128))
    else $error("bad length or single-byte value out of range");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (.*);

// ===== sim/utf8_stream_decoder_tb.sv =====
// self-checking testbench for the byte-serial utf-8 stream decoder
module utf8_stream_decoder_tb;

  // the long receiver hold plus random stalls stays far below this
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 100;
  // first result passes the queue and output register, up to five results per byte
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_BYTES = 61;

  typedef logic [utf8d_pkg::BYTE_W-1:0] byte_t;
  typedef logic [utf8d_pkg::CP_W-1:0]   cp_t;
  typedef logic [utf8d_pkg::CNT_W-1:0]  cnt_t;

  typedef enum int {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } idle_phase_e;

  typedef struct packed {
    byte_t value;
    logic  eod;
  } text_byte_t;

  typedef struct packed {
    cp_t  cp;
    logic ok;
    cnt_t used;
    logic last_run;
  } char_res_t;

  // {end_of_data, byte}: the top value of each length but four, bad leads,
  // a mismatch after four taken bytes and a sequence cut off by end of data
  localparam logic [8:0] DIRECTED_TEXT [26] = '{
    9'h000, 9'h07F,
    9'h0DF, 9'h0BF,
    9'h0EF, 9'h0BF, 9'h0BF,
    9'h0F0, 9'h09F, 9'h098, 9'h080,
    9'h0FB, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
    9'h080, 9'h0FC, 9'h0FF,
    9'h0F8, 9'h080, 9'h080, 9'h080, 9'h041,
    9'h0E2, 9'h182
  };

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  byte_t             byte_value_i  = '0;
  logic              end_of_data_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  cp_t               code_point_o;
  logic              is_valid_o;
  cnt_t              bytes_used_o;
  logic              last_of_run_o;

  text_byte_t  byte_q[$];
  char_res_t   decoded_q[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req       = 1'b0;
  logic        hold_done;
  int unsigned hold_left;
  int unsigned mismatch_cnt   = 0;
  int unsigned quiet_cycles;

  // open sequence as the decoder should hold it
  cp_t  seq_value = '0;
  cnt_t seq_len   = '0;
  cnt_t seq_taken = '0;

  utf8_stream_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_value_i  (byte_value_i),
    .end_of_data_i (end_of_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_point_o  (code_point_o),
    .is_valid_o    (is_valid_o),
    .bytes_used_o  (bytes_used_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void start_seq(input cnt_t len, input cp_t data);
    seq_len   = len;
    seq_taken = cnt_t'(1);
    seq_value = data;
  endfunction

  // every byte taken into the dropped sequence becomes one error
  function automatic void drop_seq();
    repeat (seq_taken) decoded_q.push_back('{cp: '0, ok: 1'b0, used: cnt_t'(1), last_run: 1'b0});
    seq_value = '0;
    seq_len   = '0;
    seq_taken = '0;
  endfunction

  // at most five results per byte: four dropped bytes plus one for the new lead
  function automatic void decode_byte(input byte_t b, input logic eod);
    int               first;
    logic             taken;
    utf8d_pkg::lead_e kind;
    first = decoded_q.size();
    taken = 1'b0;
    if (seq_len != 0) begin
      if (b[7:6] == 2'b10) begin
        seq_value = {seq_value[utf8d_pkg::CP_W-7:0], b[5:0]};
        seq_taken = seq_taken + cnt_t'(1);
        taken     = 1'b1;
        if (seq_taken >= seq_len) begin
          decoded_q.push_back('{cp: seq_value, ok: 1'b1, used: seq_len, last_run: 1'b0});
          seq_value = '0;
          seq_len   = '0;
          seq_taken = '0;
        end
      end else begin
        drop_seq();
      end
    end
    if (!taken) begin
      casez (b)
        8'b0???????: kind = utf8d_pkg::LEAD_ASCII;
        8'b110?????: kind = utf8d_pkg::LEAD_TWO;
        8'b1110????: kind = utf8d_pkg::LEAD_THREE;
        8'b11110???: kind = utf8d_pkg::LEAD_FOUR;
        8'b111110??: kind = utf8d_pkg::LEAD_FIVE;
        default:     kind = utf8d_pkg::LEAD_BAD;
      endcase
      case (kind)
        utf8d_pkg::LEAD_ASCII: begin
          decoded_q.push_back('{cp: cp_t'(b), ok: 1'b1, used: cnt_t'(1), last_run: 1'b0});
        end
        utf8d_pkg::LEAD_TWO:   start_seq(cnt_t'(2), cp_t'(b[4:0]));
        utf8d_pkg::LEAD_THREE: start_seq(cnt_t'(3), cp_t'(b[3:0]));
        utf8d_pkg::LEAD_FOUR:  start_seq(cnt_t'(4), cp_t'(b[2:0]));
        utf8d_pkg::LEAD_FIVE:  start_seq(cnt_t'(5), cp_t'(b[1:0]));
        default: begin
          decoded_q.push_back('{cp: '0, ok: 1'b0, used: cnt_t'(1), last_run: 1'b0});
        end
      endcase
    end
    if (eod && seq_len != 0) drop_seq();
    if (decoded_q.size() > first) decoded_q[decoded_q.size()-1].last_run = 1'b1;
  endfunction

  // mostly well-formed characters, some possibly cut short and followed by a
  // random byte, the rest single random bytes
  function automatic void queue_random_text(input int n_bytes);
    int          pushed;
    int          len;
    int          n_cont;
    int unsigned r;
    logic [7:0]  lead;
    pushed = 0;
    while (pushed < n_bytes) begin
      r   = $urandom_range(0, 99);
      len = $urandom_range(1, 5);
      if (r >= 90) begin
        byte_q.push_back('{value: 8'($urandom_range(0, 255)), eod: ($urandom_range(0, 24) == 0)});
        pushed++;
      end else begin
        case (len)
          1:       lead = {1'b0, 7'($urandom)};
          2:       lead = {3'b110, 5'($urandom)};
          3:       lead = {4'b1110, 4'($urandom)};
          4:       lead = {5'b11110, 3'($urandom)};
          default: lead = {6'b111110, 2'($urandom)};
        endcase
        n_cont = (r < 75) ? len - 1 : $urandom_range(0, len - 1);
        byte_q.push_back('{value: lead, eod: ($urandom_range(0, 24) == 0)});
        pushed++;
        repeat (n_cont) begin
          byte_q.push_back('{value: {2'b10, 6'($urandom)}, eod: ($urandom_range(0, 24) == 0)});
          pushed++;
        end
        if (r >= 75) begin
          byte_q.push_back('{value: 8'($urandom_range(0, 255)), eod: ($urandom_range(0, 24) == 0)});
          pushed++;
        end
      end
    end
  endfunction

  // byte driver: predicts on every accepted beat, then offers the next one
  always @(posedge clk_i or negedge rst_ni) begin
    text_byte_t nxt;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      byte_value_i  <= '0;
      end_of_data_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) decode_byte(byte_value_i, end_of_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = byte_q.pop_front();
          in_valid_i    <= 1'b1;
          byte_value_i  <= nxt.value;
          end_of_data_i <= nxt.eod;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    char_res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          $error("result beat with nothing expected: code_point %h is_valid %b",
                 code_point_o, is_valid_o);
          mismatch_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (code_point_o !== want.cp) begin
            $error("code_point: expected %h, got %h", want.cp, code_point_o);
            mismatch_cnt++;
          end
          if (is_valid_o !== want.ok) begin
            $error("is_valid: expected %b, got %b", want.ok, is_valid_o);
            mismatch_cnt++;
          end
          if (bytes_used_o !== want.used) begin
            $error("bytes_used: expected %0d, got %0d", want.used, bytes_used_o);
            mismatch_cnt++;
          end
          if (last_of_run_o !== want.last_run) begin
            $error("last_of_run: expected %b, got %b", want.last_run, last_of_run_o);
            mismatch_cnt++;
          end
        end
      end
      // one long hold so the command queue fills and the input stalls
      if (hold_req && !hold_done) begin
        hold_left   <= HOLD_CYCLES;
        hold_done   <= 1'b1;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    idle_phase_e ph;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (DIRECTED_TEXT[i]) begin
      byte_q.push_back('{value: DIRECTED_TEXT[i][7:0], eod: DIRECTED_TEXT[i][8]});
    end
    for (int p = PH_FREE; p <= PH_BOTH; p++) begin
      ph = idle_phase_e'(p);
      while (byte_q.size() != 0 || in_valid_i || decoded_q.size() != 0) @(negedge clk_i);
      case (ph)
        PH_FREE: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 1'b1;
        end
        PH_SEND_IDLE: begin
          send_idle_pct  = 60;
          recv_stall_pct = 0;
        end
        PH_RECV_STALL: begin
          send_idle_pct  = 0;
          recv_stall_pct = 60;
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
        end
      endcase
      queue_random_text(PHASE_BYTES);
    end
    while (byte_q.size() != 0 || in_valid_i || decoded_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (decoded_q.size() != 0) begin
      $error("%0d expected results never arrived", decoded_q.size());
    end
    if (mismatch_cnt == 0 && decoded_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
